### design/ple_pkg.sv
// Package with the operation codes and shared constants of the positional list engine.
package ple_pkg;
   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_SORT   = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned POS_W  = 7;
endpackage

### design/ple_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module ple_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### design/positional_list_engine_unit.sv
// Insert shifts entries up by one, then writes the value; delete reads the entry after the
// victim, then the victim, and shifts later ones down; a bad position, full store, short
// sort or empty read-out answers at once. Sort swaps out-of-order pairs. Read-out delivers
// each element once the output is free. One item at a time, set by the RAM's single read
// port and registered read; a new item is taken as the last result transfers. Reset
// (synchronous, active high) clears the length and the control; the RAM holds junk.
module positional_list_engine_unit
   import ple_pkg::*;
#(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_kind,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_ok,
   output logic signed [DATA_W-1:0] rsp_item_value,
   output logic [POS_W-1:0]         rsp_length,
   output logic                     rsp_empty_res,
   output logic                     rsp_last
);
   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [POS_W-1:0] CAP = POS_W'(CAPACITY);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_RD    = 9'b000000010,
      ST_WR    = 9'b000000100,
      ST_SRDI  = 9'b000001000,
      ST_SRDJ  = 9'b000010000,
      ST_SCMP  = 9'b000100000,
      ST_SWAP  = 9'b001000000,
      ST_OUT   = 9'b010000000,
      ST_ORD   = 9'b100000000
   } state_type;

   state_type          state_ff, state_in;
   kind_type           kind_ff, kind_in;
   logic [POS_W-1:0]   count_ff, count_in;
   logic [POS_W-1:0]   idx_ff, idx_in;
   logic [POS_W-1:0]   jdx_ff, jdx_in;
   logic [POS_W-1:0]   stop_ff, stop_in;
   logic [DATA_W-1:0]  hold_ff, hold_in;
   logic [DATA_W-1:0]  ival_ff, ival_in;
   logic               rv_ff, rv_in;
   logic               rok_ff, rok_in;
   logic [DATA_W-1:0]  rval_ff, rval_in;
   logic               rlast_ff, rlast_in;
   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [DATA_W-1:0]  wr_data, rd_data;
   logic               take, out_free;

   ple_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign out_free  = !rv_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign take      = req_valid && req_ready;

   // Sequencer: shifts, sort exchanges and read-out walk the RAM one entry at a time.
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      jdx_in   = jdx_ff;
      stop_in  = stop_ff;
      hold_in  = hold_ff;
      ival_in  = ival_ff;
      rv_in    = rv_ff && !rsp_ready;
      rok_in   = rok_ff;
      rval_in  = rval_ff;
      rlast_in = rlast_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff[AW-1:0];
      wr_data  = hold_ff;
      rd_addr  = idx_ff[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               kind_in = kind_type'(req_kind);
               ival_in = req_value;
               unique case (kind_type'(req_kind))
                  KIND_INSERT: begin
                     if (req_position == '0 || req_position > count_ff + 7'd1 ||
                         count_ff >= CAP) begin
                        rv_in = 1'b1; rok_in = 1'b0; rval_in = '0; rlast_in = 1'b1;
                     end else begin
                        // Walk from the tail down, moving each entry up by one.
                        idx_in   = count_ff;
                        stop_in  = req_position - 7'd1;
                        state_in = ST_RD;
                     end
                  end
                  KIND_DELETE: begin
                     if (req_position == '0 || req_position > count_ff) begin
                        rv_in = 1'b1; rok_in = 1'b0; rval_in = '0; rlast_in = 1'b1;
                     end else begin
                        // Read the entry after the victim, then the victim, then move later entries down.
                        idx_in   = req_position - 7'd1;
                        state_in = ST_RD;
                     end
                  end
                  KIND_SORT: begin
                     if (count_ff < 7'd2) begin
                        rv_in = 1'b1; rok_in = 1'b1; rval_in = '0; rlast_in = 1'b1;
                     end else begin
                        idx_in   = '0;
                        jdx_in   = 7'd1;
                        state_in = ST_SRDI;
                     end
                  end
                  KIND_READ: begin
                     if (count_ff == '0) begin
                        rv_in = 1'b1; rok_in = 1'b0; rval_in = '0; rlast_in = 1'b1;
                     end else begin
                        idx_in   = '0;
                        state_in = ST_ORD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RD: begin
            if (kind_ff == KIND_INSERT) begin
               if (idx_ff == stop_ff) begin
                  // Slot is free now: place the new value.
                  wr_en    = 1'b1;
                  wr_data  = ival_ff;
                  count_in = count_ff + 7'd1;
                  rv_in = 1'b1; rok_in = 1'b1; rval_in = '0; rlast_in = 1'b1;
                  stop_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  rd_addr  = AW'(idx_ff - 7'd1);
                  state_in = ST_WR;
               end
            end else begin
               rd_addr  = idx_ff[AW-1:0];
               if (idx_ff + 7'd1 < count_ff) begin
                  rd_addr = AW'(idx_ff + 7'd1);
               end
               state_in = ST_WR;
            end
         end
         ST_WR: begin
            if (kind_ff == KIND_INSERT) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               idx_in   = idx_ff - 7'd1;
               state_in = ST_RD;
            end else if (stop_ff == '0 && idx_ff != 7'h7F) begin
               // First pass of a delete: rd_data is the entry after the victim.
               // The victim itself is read separately below.
               hold_in  = rd_data;
               rd_addr  = idx_ff[AW-1:0];
               stop_in  = 7'd1;
               state_in = ST_WR;
               idx_in   = idx_ff;
               jdx_in   = 7'h7F;
            end else begin
               if (jdx_ff == 7'h7F) begin
                  // Victim value available.
                  rval_in = rd_data;
                  jdx_in  = '0;
               end
               if (idx_ff + 7'd1 < count_ff) begin
                  wr_en    = 1'b1;
                  wr_data  = hold_ff;
                  idx_in   = idx_ff + 7'd1;
                  rd_addr  = AW'(idx_ff + 7'd2);
                  state_in = ST_SCMP;
               end else begin
                  count_in = count_ff - 7'd1;
                  rv_in = 1'b1; rok_in = 1'b1; rlast_in = 1'b1;
                  stop_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SRDI: begin
            rd_addr  = idx_ff[AW-1:0];
            state_in = ST_SRDJ;
         end
         ST_SRDJ: begin
            hold_in  = rd_data;
            rd_addr  = jdx_ff[AW-1:0];
            state_in = ST_SCMP;
         end
         ST_SCMP: begin
            if (kind_ff == KIND_DELETE) begin
               // Delete shift: rd_data is the entry just after slot idx, and it moves down into slot idx.
               hold_in  = rd_data;
               if (idx_ff + 7'd1 < count_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = idx_ff[AW-1:0];
                  wr_data  = rd_data;
                  idx_in   = idx_ff + 7'd1;
                  rd_addr  = AW'(idx_ff + 7'd2);
                  state_in = ST_SCMP;
               end else begin
                  count_in = count_ff - 7'd1;
                  rv_in = 1'b1; rok_in = 1'b1; rlast_in = 1'b1;
                  stop_in  = '0;
                  state_in = ST_IDLE;
               end
            end else if ($signed(hold_ff) > $signed(rd_data)) begin
               // Slot i holds the larger: exchange.
               wr_en    = 1'b1;
               wr_addr  = idx_ff[AW-1:0];
               wr_data  = rd_data;
               ival_in  = hold_ff;
               hold_in  = rd_data;
               state_in = ST_SWAP;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SWAP: begin
            wr_en    = 1'b1;
            wr_addr  = jdx_ff[AW-1:0];
            wr_data  = ival_ff;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Advance the pair (i, j); slot i stays in hold_ff.
            if (jdx_ff + 7'd1 < count_ff) begin
               jdx_in   = jdx_ff + 7'd1;
               rd_addr  = AW'(jdx_ff + 7'd1);
               state_in = ST_SCMP;
            end else if (idx_ff + 7'd2 < count_ff) begin
               idx_in   = idx_ff + 7'd1;
               jdx_in   = idx_ff + 7'd2;
               state_in = ST_SRDI;
            end else begin
               rv_in = 1'b1; rok_in = 1'b1; rval_in = '0; rlast_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_ORD: begin
            // Read-out: issue a read, then deliver its data once the output is free.
            if (out_free) begin
               if (stop_ff == '0) begin
                  rd_addr = idx_ff[AW-1:0];
                  stop_in = 7'd1;
               end else begin
                  rv_in    = 1'b1;
                  rok_in   = 1'b1;
                  rval_in  = rd_data;
                  rlast_in = (idx_ff + 7'd1 == count_ff);
                  stop_in  = '0;
                  idx_in   = idx_ff + 7'd1;
                  if (idx_ff + 7'd1 == count_ff) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
         stop_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
         stop_ff  <= stop_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      idx_ff   <= idx_in;
      jdx_ff   <= jdx_in;
      hold_ff  <= hold_in;
      ival_ff  <= ival_in;
      rok_ff   <= rok_in;
      rval_ff  <= rval_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_ok         = rok_ff;
   assign rsp_item_value = rval_ff;
   assign rsp_length     = count_ff;
   assign rsp_empty_res  = (count_ff == '0);
   assign rsp_last       = rlast_ff;

`ifndef SYNTHESIS
   a_len_cap: assert property (@(posedge clock) disable iff (reset) count_ff <= CAP)
      else $error("length above capacity");
   a_len_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff == $past(count_ff) || count_ff == $past(count_ff) + 7'd1 ||
       count_ff + 7'd1 == $past(count_ff)))
      else $error("length moved by more than one");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request taken while busy");
`endif
endmodule
